[sv/hec_pkg.sv]
// ----------------------------------------------------------------------------
// hec_pkg
// Shared types and constants for the Huffman encoder with bit packer.
// ----------------------------------------------------------------------------
package hec_pkg;

   // field widths fixed by the interface
   localparam int SYM_W   = 8;
   localparam int LEN_W   = 6;
   localparam int CODE_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int SYMBOLS = 256;
   localparam int PAD_W   = 3;

   // item modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

   // input item
   typedef struct packed {
      logic [1:0]        mode;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  code_len;
      logic [CODE_W-1:0] code_bits;
   } req_type;

   // result item
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   // looked-up item handed from the table stage to the packer
   typedef struct packed {
      logic [1:0]        mode;
      logic [LEN_W-1:0]  code_len;
      logic [CODE_W-1:0] code_bits;
   } lookup_type;

   // table memory word: length over code
   localparam int ENTRY_W = LEN_W + CODE_W;

endpackage

[sv/hec_ram.sv]
// ----------------------------------------------------------------------------
// hec_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hec_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/hec_table.sv]
// ----------------------------------------------------------------------------
// hec_table
// Code table stage: takes input transfers, writes loads into the table
// memory and reads the entry for encodes, presenting the looked-up item
// in the cycle after the transfer is taken.
// ----------------------------------------------------------------------------
module hec_table #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hec_pkg::req_type    req,
   output logic                lk_valid,
   output hec_pkg::lookup_type lk,
   input  logic                lk_take
);

   localparam int LEN_W1 = hec_pkg::LEN_W + 2;

   logic                            accept;
   logic                            s1_valid_ff, s1_valid_in;
   logic [1:0]                      mode_ff;
   logic [hec_pkg::SYMBOLS-1:0]     vld_ff, vld_in;
   logic                            vld_rd_ff;
   logic [hec_pkg::LEN_W-1:0]       len_clamped;
   logic [hec_pkg::ENTRY_W-1:0]     rd_data;
   logic                            is_load, is_encode;

   assign req_stall = s1_valid_ff && !lk_take;
   assign accept    = req_valid && !req_stall;
   assign is_load   = req.mode == hec_pkg::MODE_LOAD;
   assign is_encode = req.mode == hec_pkg::MODE_ENCODE;

   // overlong codes are stored at the maximum length
   assign len_clamped = ((LEN_W1'(req.code_len)) > LEN_W1'(MAX_CODE_LEN))
                      ? hec_pkg::LEN_W'(MAX_CODE_LEN) : req.code_len;

   hec_ram #(
      .WIDTH (hec_pkg::ENTRY_W),
      .DEPTH (hec_pkg::SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept && is_load),
      .wr_addr (req.symbol),
      .wr_data ({len_clamped, req.code_bits}),
      .rd_en   (accept && is_encode),
      .rd_addr (req.symbol),
      .rd_data (rd_data)
   );

   // per-entry written flags, an unwritten entry reads as length zero
   always_comb begin
      vld_in = vld_ff;
      if (accept && is_load) begin
         vld_in[req.symbol] = 1'b1;
      end
   end

   // stage register handshake
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (lk_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         vld_ff      <= vld_in;
      end
   end

   // item payload, captured with the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req.mode;
         vld_rd_ff <= vld_ff[req.symbol];
      end
   end

   assign lk_valid     = s1_valid_ff;
   assign lk.mode      = mode_ff;
   assign lk.code_len  = vld_rd_ff ? rd_data[hec_pkg::ENTRY_W-1 -: hec_pkg::LEN_W] : '0;
   assign lk.code_bits = rd_data[hec_pkg::CODE_W-1:0];

endmodule

[sv/hec_packer.sv]
// ----------------------------------------------------------------------------
// hec_packer
// MSB-first bit packer: merges code words into a left-aligned bit buffer,
// sends one completed byte per cycle while the output is not stalled, and handles the flush sequence.
// ----------------------------------------------------------------------------
module hec_packer #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                lk_valid,
   input  hec_pkg::lookup_type lk,
   output logic                lk_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hec_pkg::rsp_type    rsp
);

   localparam int BUF_W = MAX_CODE_LEN + hec_pkg::BYTE_W;
   localparam int CNT_W = $clog2(BUF_W + 1);

   logic [BUF_W-1:0]         buf_ff, buf_in, buf_e;
   logic [CNT_W-1:0]         cnt_ff, cnt_in, cnt_e;
   logic                     fpend_ff, fpend_in, fpend_e;
   logic [hec_pkg::PAD_W-1:0] pad_ff, pad_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   hec_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     has_byte, slot_free, emit, room, needs_room, take;
   logic [BUF_W-1:0]         code_ext, code_mask;
   logic [CNT_W-1:0]         shift_amt;

   assign has_byte  = cnt_ff >= CNT_W'(hec_pkg::BYTE_W);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = (has_byte || fpend_ff) && slot_free;

   // buffer state after this cycle's byte leaves
   always_comb begin
      buf_e   = buf_ff;
      cnt_e   = cnt_ff;
      fpend_e = fpend_ff;
      if (emit && has_byte) begin
         buf_e = buf_ff << hec_pkg::BYTE_W;
         cnt_e = cnt_ff - CNT_W'(hec_pkg::BYTE_W);
      end else if (emit) begin
         buf_e   = '0;
         cnt_e   = '0;
         fpend_e = 1'b0;
      end
   end

   // take an encode or flush once only a partial byte is left and no flush is pending; other items at once
   assign needs_room = (lk.mode == hec_pkg::MODE_ENCODE) || (lk.mode == hec_pkg::MODE_FLUSH);
   assign room       = (cnt_e < CNT_W'(hec_pkg::BYTE_W)) && !fpend_e;
   assign take       = lk_valid && (room || !needs_room);
   assign lk_take    = take;

   // code word widened to the buffer, bits above the stored word read as zero
   always_comb begin
      for (int i = 0; i < BUF_W; i++) begin
         code_ext[i] = (i < hec_pkg::CODE_W) ? lk.code_bits[i % hec_pkg::CODE_W] : 1'b0;
      end
   end

   assign code_mask = ~({BUF_W{1'b1}} << lk.code_len);
   assign shift_amt = CNT_W'(BUF_W) - cnt_e - CNT_W'(lk.code_len);

   // merge the incoming item
   always_comb begin
      buf_in   = buf_e;
      cnt_in   = cnt_e;
      fpend_in = fpend_e;
      pad_in   = pad_ff;
      if (take) begin
         unique case (lk.mode)
            hec_pkg::MODE_ENCODE: begin
               buf_in = buf_e | ((code_ext & code_mask) << shift_amt);
               cnt_in = cnt_e + CNT_W'(lk.code_len);
            end
            hec_pkg::MODE_FLUSH: begin
               fpend_in = 1'b1;
               if (cnt_e != '0) begin
                  // partial byte is already zero-padded in the buffer
                  cnt_in = CNT_W'(hec_pkg::BYTE_W);
                  pad_in = hec_pkg::PAD_W'(CNT_W'(hec_pkg::BYTE_W) - cnt_e);
               end else begin
                  pad_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (has_byte) begin
            rsp_in.out_byte = buf_ff[BUF_W-1 -: hec_pkg::BYTE_W];
            rsp_in.last     = 1'b0;
         end else begin
            rsp_in.out_byte = hec_pkg::BYTE_W'(pad_ff);
            rsp_in.last     = 1'b1;
         end
      end else if (slot_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         fpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         fpend_ff     <= fpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff <= pad_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[sv/huffman_encoder_bit_packer.sv]
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer
// Table-driven Huffman encoder with MSB-first byte packing.
// ----------------------------------------------------------------------------
// Load transfers write a symbol's code length and code word into a 256-entry
// table memory; encode transfers look the symbol up and append its code,
// first bit first, to the packed stream; a flush transfer zero-pads the
// partial byte, sends it, then sends a byte holding the pad count with last
// set. One item is taken per cycle while each item yields at most one byte
// and the output is not stalled; the packer sends one byte per cycle through
// its output register. An item completing more bytes holds the next encode
// or flush until under a byte is left, a flush of a partial byte until the
// pad byte is sent. Results pass the table read, packer and output register
// in that order. Lengths read as zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hec_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hec_pkg::rsp_type rsp
);

   logic                lk_valid;
   logic                lk_take;
   hec_pkg::lookup_type lk;

   // table lookup stage
   hec_table #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .lk_valid  (lk_valid),
      .lk        (lk),
      .lk_take   (lk_take)
   );

   // bit packer and output register
   hec_packer #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .lk_valid  (lk_valid),
      .lk        (lk),
      .lk_take   (lk_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

[sv/hec_checker.sv]
// ----------------------------------------------------------------------------
// hec_checker
// Port-level checks for the Huffman encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hec_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input hec_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hec_pkg::rsp_type rsp
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result changed");

   // pad count on the final byte is below eight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.last |-> rsp.out_byte[7:3] == 5'd0)
      else $error("pad count out of range");

   // no result right out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side ready right out of reset
   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind huffman_encoder_bit_packer hec_checker u_hec_checker (.*);

[dv/huffman_encoder_bit_packer_checker.sv]
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer_checker
// Watches both channels of the Huffman encoder, predicts the packed bytes
// from each accepted transfer and compares them with the bytes sent out.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer_checker #(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  hec_pkg::req_type req,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  hec_pkg::rsp_type rsp,
   output int               failure_count,
   output int               pending_count
);
   import hec_pkg::*;

   // shadow copy of the code table and the packer
   int                len_tbl  [SYMBOLS];
   logic [CODE_W-1:0] code_tbl [SYMBOLS];
   logic [BYTE_W-1:0] partial;
   int                fill;

   // bytes still to come, oldest first
   rsp_type expected_bytes[$];

   initial failure_count = 0;
   initial pending_count = 0;

   task automatic report_mismatch(input string what);
      failure_count++;
      if (failure_count <= 100)
         $display("%0t checker: %s", $time, what);
   endtask

   // append one code word, first bit first, and queue each full byte
   task automatic append_code(input int len, input logic [CODE_W-1:0] word);
      int pos;
      for (pos = len - 1; pos >= 0; pos--) begin
         partial = {partial[BYTE_W-2:0], (pos < CODE_W) ? word[pos] : 1'b0};
         fill++;
         if (fill == BYTE_W) begin
            expected_bytes.push_back('{out_byte: partial, last: 1'b0});
            partial = '0;
            fill = 0;
         end
      end
   endtask

   // work out the bytes caused by one accepted transfer
   task automatic predict_bytes(input req_type item);
      int pad;
      case (item.mode)
         MODE_LOAD: begin
            len_tbl[item.symbol]  = (int'(item.code_len) > MAX_CODE_LEN) ?
                                    MAX_CODE_LEN : int'(item.code_len);
            code_tbl[item.symbol] = item.code_bits;
         end
         MODE_ENCODE: begin
            append_code(len_tbl[item.symbol], code_tbl[item.symbol]);
         end
         MODE_FLUSH: begin
            pad = 0;
            if (fill > 0) begin
               pad = BYTE_W - fill;
               expected_bytes.push_back('{out_byte: BYTE_W'(partial << pad), last: 1'b0});
            end
            expected_bytes.push_back('{out_byte: BYTE_W'(pad), last: 1'b1});
            partial = '0;
            fill = 0;
         end
         default: ;
      endcase
   endtask

   // compare one sent byte with the oldest prediction
   task automatic check_byte(input rsp_type got);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
      end else begin
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      got.out_byte, want.out_byte));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, predicted %0b", got.last, want.last));
      end
   endtask

   // sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (len_tbl[i]) len_tbl[i] = 0;
         foreach (code_tbl[i]) code_tbl[i] = '0;
         partial = '0;
         fill = 0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_bytes(req);
         if (rsp_valid && !rsp_stall)
            check_byte(rsp);
      end
      pending_count = expected_bytes.size();
   end

endmodule

[dv/huffman_encoder_bit_packer_test.sv]
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer_test
// Drives table loads, symbol encodes, flushes and ignored items into the
// Huffman encoder with random idling on both channels; the checker beside
// the block predicts every packed byte and counts mismatches.
// ----------------------------------------------------------------------------
module huffman_encoder_bit_packer_test;
   import hec_pkg::*;

   localparam int         MAX_CODE_LEN = 32;
   localparam int         RANDOM_ITEMS = 350;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   int failure_count;
   int pending_count;
   int cycle_count = 0;
   int stall_left  = 0;
   bit quiet       = 1'b0;

   // symbols whose table entry has been written
   bit          loaded [SYMBOLS];
   logic [7:0]  loaded_syms[$];

   always #5 clock = ~clock;

   huffman_encoder_bit_packer #(.MAX_CODE_LEN(MAX_CODE_LEN)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   huffman_encoder_bit_packer_checker #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp           (rsp),
      .failure_count (failure_count),
      .pending_count (pending_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver stall in bursts: mostly short, a few long
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall  <= ($urandom_range(99) < 35);
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 50) :
                                                  $urandom_range(1, 4);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // one transfer on the input channel, with a random gap in front
   task automatic send(input req_type item);
      int gap;
      int roll;
      roll = $urandom_range(99);
      gap  = quiet ? 0 :
             (roll < 55) ? 0 :
             (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.mode == MODE_LOAD && !loaded[item.symbol]) begin
         loaded[item.symbol] = 1'b1;
         loaded_syms.push_back(item.symbol);
      end
   endtask

   function automatic req_type make_item(input logic [1:0] mode, input logic [7:0] symbol,
                                         input logic [5:0] len, input logic [31:0] word);
      req_type item;
      item.mode      = mode;
      item.symbol    = symbol;
      item.code_len  = len;
      item.code_bits = word;
      return item;
   endfunction

   // random item: mostly encodes of loaded symbols, some loads, some flushes and unused modes
   function automatic req_type random_item();
      req_type item;
      int      roll;
      item = make_item(MODE_ENCODE, 8'($urandom()), 6'($urandom()), $urandom());
      roll = $urandom_range(99);
      if (roll < 22) begin
         item.mode = MODE_LOAD;
         roll = $urandom_range(99);
         item.code_len = 6'((roll < 60) ? $urandom_range(1, 8) :
                            (roll < 80) ? $urandom_range(9, 32) :
                            (roll < 90) ? $urandom_range(33, 63) : 0);
      end else if (roll < 86) begin
         item.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      end else if (roll < 94) begin
         item.mode = MODE_FLUSH;
      end else begin
         item.mode = MODE_UNUSED;
      end
      return item;
   endfunction

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table extremes, unused mode, overlong load, flush cases
      send(make_item(MODE_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF));
      send(make_item(MODE_LOAD,   8'hFF, 6'd32, 32'hFFFF_FFFF));
      send(make_item(MODE_LOAD,   8'h01, 6'd63, 32'h8000_0001));
      send(make_item(MODE_LOAD,   8'h02, 6'd1,  32'h0000_0001));
      send(make_item(MODE_LOAD,   8'h03, 6'd8,  32'h0000_00A5));
      send(make_item(MODE_LOAD,   8'h04, 6'd3,  32'hAAAA_AAAD));
      send(make_item(MODE_LOAD,   8'h80, 6'd5,  32'h5555_5556));
      send(make_item(MODE_ENCODE, 8'h00, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h02, 6'd63, 32'hFFFF_FFFF));
      send(make_item(MODE_FLUSH,  8'h00, 6'd0,  32'h0));
      send(make_item(MODE_FLUSH,  8'hFF, 6'd63, 32'hFFFF_FFFF));
      send(make_item(MODE_ENCODE, 8'h03, 6'd0,  32'h0));
      send(make_item(MODE_FLUSH,  8'h00, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'hFF, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h01, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h04, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h02, 6'd0,  32'h0));
      send(make_item(MODE_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF));
      send(make_item(MODE_ENCODE, 8'h80, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h04, 6'd0,  32'h0));
      send(make_item(MODE_FLUSH,  8'h00, 6'd0,  32'h0));
      send(make_item(MODE_LOAD,   8'h02, 6'd0,  32'h0000_0001));
      send(make_item(MODE_ENCODE, 8'h02, 6'd0,  32'h0));
      send(make_item(MODE_ENCODE, 8'h80, 6'd0,  32'h0));
      send(make_item(MODE_FLUSH,  8'h00, 6'd0,  32'h0));

      // random part, with a stretch of back-to-back transfers and no stall
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 150 && i < 210);
         send(random_item());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (failure_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
